### rtl/utfsf_pkg.sv
// Package for the UTF-8 script filter and space trimmer.
// Holds shared constants, the controller/datapath command and status types,
// and the helper functions for space codes and script ranges.
package utfsf_pkg;

    localparam int SPACE_DEPTH_DEF = 16;

    // result source select
    localparam logic [1:0] SRC_SPACE = 2'd0;
    localparam logic [1:0] SRC_LIST  = 2'd1;
    localparam logic [1:0] SRC_MARK  = 2'd2;

    // configuration register indexes
    localparam logic CFG_ALLOW_JP = 1'b0;
    localparam logic CFG_ALLOW_KR = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic [1:0] src;
        logic       sp_inc;
        logic       li_inc;
        logic       idle;
    } t_cmd;

    typedef struct packed {
        logic plan_list;
        logic plan_space;
        logic plan_end;
        logic out_free;
        logic sp_last;
        logic li_last;
    } t_status;

    // {is_space, code}: 0 space, 1 tab, 2 CR, 3 LF
    function automatic logic [2:0] space_code(input logic [7:0] b);
        logic [2:0] r;
        case (b)
            8'h20:   r = 3'b100;
            8'h09:   r = 3'b101;
            8'h0D:   r = 3'b110;
            8'h0A:   r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_byte(input logic [1:0] c);
        logic [7:0] r;
        case (c)
            2'd0:    r = 8'h20;
            2'd1:    r = 8'h09;
            2'd2:    r = 8'h0D;
            default: r = 8'h0A;
        endcase
        return r;
    endfunction

    function automatic logic japanese_cp(input logic [20:0] v);
        return (v >= 21'h3040 && v <= 21'h30FF) || (v >= 21'h31F0 && v <= 21'h31FF) ||
               (v >= 21'hFF65 && v <= 21'hFF9F) || (v >= 21'h1AFF0 && v <= 21'h1AFFF) ||
               (v >= 21'h1B000 && v <= 21'h1B16F);
    endfunction

    function automatic logic korean_cp(input logic [20:0] v);
        return (v >= 21'h1100 && v <= 21'h11FF) || (v >= 21'h3130 && v <= 21'h318F) ||
               (v >= 21'hA960 && v <= 21'hA97F) || (v >= 21'hAC00 && v <= 21'hD7FF) ||
               (v >= 21'hFFA0 && v <= 21'hFFDC);
    endfunction

endpackage

### rtl/utf8_script_filter_trim.sv
// Order: a request's results are loaded into the output register one by one after
// acceptance; held spaces that precede them are released first, each one read
// from the store and then loaded into the output register.
// Output stalls hold each load; the controller takes the next request only after
// the last result.
// Reset (synchronous, active low) clears control state; both script enables reset to 1.
module utf8_script_filter_trim #(
    parameter int SPACE_DEPTH = utfsf_pkg::SPACE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_empty_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_text,
    output logic       o_space_overflow
);

    utfsf_pkg::t_cmd    cmd;
    utfsf_pkg::t_status status;

    utfsf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    utfsf_dp #(.SPACE_DEPTH(SPACE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_text_byte     (i_text_byte),
        .i_end_of_text   (i_end_of_text),
        .i_empty_text    (i_empty_text),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_text  (o_last_of_text),
        .o_space_overflow(o_space_overflow)
    );

`ifndef NO_ASSERTIONS
    // an ending request always yields at least one result
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_end_of_text || i_empty_text)) |=> o_in_stall)
        else $error("ending request produced no work");

    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> o_last_of_text)
        else $error("end marker without last flag");

    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_out_byte == 8'd0))
        else $error("end marker carries a byte");
`endif

endmodule

### rtl/utfsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utfsf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/utfsf_ctrl.sv
// Controller state machine for the UTF-8 script filter and space trimmer.
// Uses utfsf_pkg command and status types.
module utfsf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  utfsf_pkg::t_status i_status,
    output utfsf_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SP_RD  = 3'd1;
    localparam logic [2:0] ST_SP_OUT = 3'd2;
    localparam logic [2:0] ST_LIST   = 3'd3;
    localparam logic [2:0] ST_MARK   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.plan_list) begin
                        n_state = i_status.plan_space ? ST_SP_RD : ST_LIST;
                    end else if (i_status.plan_end) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_SP_RD: begin
                n_state = ST_SP_OUT;
            end
            ST_SP_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.src    = utfsf_pkg::SRC_SPACE;
                    o_cmd.sp_inc = 1'b1;
                    n_state = i_status.sp_last ? ST_LIST : ST_SP_RD;
                end
            end
            ST_LIST: begin
                if (i_status.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.src    = utfsf_pkg::SRC_LIST;
                    o_cmd.li_inc = 1'b1;
                    if (i_status.li_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MARK: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = utfsf_pkg::SRC_MARK;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/utfsf_dp.sv
// Datapath: UTF-8 sequence buffer, script filter, held-space store and
// output register. Uses utfsf_pkg and utfsf_ram.
module utfsf_dp #(
    parameter int SPACE_DEPTH = utfsf_pkg::SPACE_DEPTH_DEF,
    localparam int AW  = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1,
    localparam int HCW = $clog2(SPACE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic               i_cfg_data,
    input  logic [7:0]         i_text_byte,
    input  logic               i_end_of_text,
    input  logic               i_empty_text,
    input  utfsf_pkg::t_cmd    i_cmd,
    output utfsf_pkg::t_status o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_last_of_text,
    output logic               o_space_overflow
);

    logic           r_allow_jp, r_allow_kr;
    logic [7:0]     r_pend [3];
    logic [1:0]     r_pc;
    logic [2:0]     r_ew;
    logic [HCW-1:0] r_hc;
    logic           r_seen, r_ovf;

    // per-request plan
    logic [7:0]     r_lst [4];
    logic [2:0]     r_ln;
    logic [1:0]     r_li;
    logic           r_end;
    logic           r_res_ovf;
    logic [HCW-1:0] r_sp_n;
    logic [AW-1:0]  r_sp_idx;
    logic           r_wr_pend;
    logic [1:0]     r_wr_code;
    logic [AW-1:0]  r_wr_addr;

    logic [1:0]     ram_rdata;

    // plan for the incoming request
    logic [7:0]     l [4];
    logic [2:0]     ln;
    logic [7:0]     np [3];
    logic [1:0]     npc;
    logic [2:0]     new_ew;
    logic           hold, set_ovf, fresh, ending, is_open, is_cont, keep;
    logic [2:0]     sc;
    logic [2:0]     lead_w;
    logic [20:0]    cp;
    logic [2:0]     idx;
    logic           out_free;

    assign is_open = (r_ew != 3'd0) && (r_pc != 2'd0);
    assign is_cont = (i_text_byte[7:6] == 2'b10);
    assign sc      = utfsf_pkg::space_code(i_text_byte);
    assign ending  = i_empty_text | i_end_of_text;

    always_comb begin
        if (i_text_byte[7:5] == 3'b110) begin
            lead_w = 3'd2;
        end else if (i_text_byte[7:4] == 4'b1110) begin
            lead_w = 3'd3;
        end else if (i_text_byte[7:3] == 5'b11110) begin
            lead_w = 3'd4;
        end else begin
            lead_w = 3'd0;
        end
    end

    always_comb begin
        case (r_ew)
            3'd2:    cp = {10'd0, r_pend[0][4:0], i_text_byte[5:0]};
            3'd3:    cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], i_text_byte[5:0]};
            default: cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0],
                           i_text_byte[5:0]};
        endcase
        keep = !((!r_allow_jp && utfsf_pkg::japanese_cp(cp)) ||
                 (!r_allow_kr && utfsf_pkg::korean_cp(cp)));
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l[i] = 8'd0;
        end
        for (int i = 0; i < 3; i++) begin
            np[i] = r_pend[i];
        end
        ln      = 3'd0;
        npc     = r_pc;
        new_ew  = r_ew;
        hold    = 1'b0;
        set_ovf = 1'b0;
        fresh   = 1'b0;
        idx     = 3'd0;
        if (!i_empty_text) begin
            if (!is_open) begin
                npc    = 2'd0;
                new_ew = 3'd0;
                fresh  = 1'b1;
            end else if (!is_cont) begin
                // broken sequence: flush buffered bytes raw
                for (int i = 0; i < 3; i++) begin
                    if (i < int'(r_pc)) begin
                        l[i] = r_pend[i];
                    end
                end
                ln     = {1'b0, r_pc};
                npc    = 2'd0;
                new_ew = 3'd0;
                fresh  = 1'b1;
            end else if (({1'b0, r_pc} + 3'd1) < r_ew) begin
                np[r_pc] = i_text_byte;
                npc      = r_pc + 2'd1;
            end else begin
                if (keep) begin
                    for (int i = 0; i < 3; i++) begin
                        if (i < int'(r_pc)) begin
                            l[i] = r_pend[i];
                        end
                    end
                    l[r_pc] = i_text_byte;
                    ln      = {1'b0, r_pc} + 3'd1;
                end
                npc    = 2'd0;
                new_ew = 3'd0;
            end
            if (fresh) begin
                if (lead_w != 3'd0) begin
                    np[0]  = i_text_byte;
                    npc    = 2'd1;
                    new_ew = lead_w;
                end else if (sc[2]) begin
                    if (r_seen || (ln != 3'd0)) begin
                        // flushed content empties the store first
                        if ((ln != 3'd0) || (r_hc < HCW'(SPACE_DEPTH))) begin
                            hold = 1'b1;
                        end else begin
                            set_ovf = 1'b1;
                        end
                    end
                end else begin
                    l[ln[1:0]] = i_text_byte;
                    ln         = ln + 3'd1;
                end
            end
        end
        if (ending) begin
            // cut off by the end: pass buffered bytes raw
            for (int i = 0; i < 3; i++) begin
                idx = ln + 3'(i);
                if ((i < int'(npc)) && (idx < 3'd4)) begin
                    l[idx[1:0]] = np[i];
                end
            end
            ln     = ln + {1'b0, npc};
            npc    = 2'd0;
            new_ew = 3'd0;
        end
    end

    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_status            = '0;
        o_status.plan_list  = (ln != 3'd0);
        o_status.plan_space = (r_hc != '0);
        o_status.plan_end   = ending;
        o_status.out_free   = out_free;
        o_status.sp_last    = ({{(HCW+1-AW){1'b0}}, r_sp_idx} + (HCW+1)'(1))
                              == {1'b0, r_sp_n};
        o_status.li_last    = ({1'b0, r_li} + 3'd1) == r_ln;
    end

    utfsf_ram #(.WIDTH(2), .DEPTH(SPACE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_wr_pend && i_cmd.idle),
        .i_waddr(r_wr_addr),
        .i_wdata(r_wr_code),
        .i_raddr(r_sp_idx),
        .o_rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_jp  <= 1'b1;
            r_allow_kr  <= 1'b1;
            r_pc        <= 2'd0;
            r_ew        <= 3'd0;
            r_hc        <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_wr_pend   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    utfsf_pkg::CFG_ALLOW_JP: r_allow_jp <= i_cfg_data;
                    utfsf_pkg::CFG_ALLOW_KR: r_allow_kr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.idle) begin
                r_wr_pend <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_pc      <= npc;
                r_ew      <= new_ew;
                r_wr_pend <= hold && !ending;
                if (ending) begin
                    r_hc   <= '0;
                    r_seen <= 1'b0;
                    r_ovf  <= 1'b0;
                end else begin
                    if (hold) begin
                        r_hc <= ((ln != 3'd0) ? '0 : r_hc) + HCW'(1);
                    end else if (ln != 3'd0) begin
                        r_hc <= '0;
                    end
                    r_seen <= r_seen | (ln != 3'd0);
                    r_ovf  <= r_ovf | set_ovf;
                end
            end
            if (i_cmd.load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int i = 0; i < 3; i++) begin
                r_pend[i] <= ending ? 8'd0 : np[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_lst[i] <= l[i];
            end
            r_ln      <= ln;
            r_li      <= 2'd0;
            r_end     <= ending;
            r_res_ovf <= (ln != 3'd0) ? r_ovf : (r_ovf | set_ovf);
            r_sp_n    <= (ln != 3'd0) ? r_hc : '0;
            r_sp_idx  <= '0;
            r_wr_code <= sc[1:0];
            r_wr_addr <= (ln != 3'd0) ? '0 : r_hc[AW-1:0];
        end
        if (i_cmd.sp_inc) begin
            r_sp_idx <= r_sp_idx + AW'(1);
        end
        if (i_cmd.li_inc) begin
            r_li <= r_li + 2'd1;
        end
        if (i_cmd.load) begin
            case (i_cmd.src)
                utfsf_pkg::SRC_SPACE: begin
                    o_out_byte     <= utfsf_pkg::code_byte(ram_rdata);
                    o_byte_valid   <= 1'b1;
                    o_last_of_text <= 1'b0;
                end
                utfsf_pkg::SRC_LIST: begin
                    o_out_byte     <= r_lst[r_li];
                    o_byte_valid   <= 1'b1;
                    o_last_of_text <= r_end && o_status.li_last;
                end
                default: begin
                    o_out_byte     <= 8'd0;
                    o_byte_valid   <= 1'b0;
                    o_last_of_text <= 1'b1;
                end
            endcase
            o_space_overflow <= r_res_ovf;
        end
    end

endmodule
